### hw/rtl/pivm_pkg.sv
package pivm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MSTART,
    ST_MWAIT,
    ST_NEXT,
    ST_FINISH
  } state_t;

  // multiply sequence for the exact ellipsoid test
  typedef enum logic [3:0] {
    MS_BC,
    MS_AC,
    MS_AB,
    MS_U,
    MS_V,
    MS_W,
    MS_R,
    MS_UU,
    MS_VV,
    MS_WW,
    MS_RR
  } mstep_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;
  localparam logic SHAPE_BOX = 1'b0;
  localparam logic SHAPE_ELLIPSOID = 1'b1;

endpackage

### hw/rtl/pivm_ram.sv
module pivm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/pivm_mul.sv
module pivm_mul #(
  parameter int XW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [XW-1:0]   a,
  input  logic [XW-1:0]   b,
  output logic            done,
  output logic [2*XW-1:0] p
);

  logic            busy;
  logic [2*XW-1:0] mc;
  logic [XW-1:0]   mp;
  logic [2*XW-1:0] acc;

  // finishes as soon as the remaining multiplier bits are all zero
  assign done = busy && (mp == '0);
  assign p = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= (2*XW)'(a);
      mp <= b;
      acc <= '0;
    end else if (busy && !done) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

endmodule

### hw/rtl/point_in_volume_mask_regions_core.sv
// channel  direction  handshake               payload
// in       in         in_valid / in_stall     kind, mask_index, mask_shape, mask_is_hole,
//                                             relative, coord_a .. coord_f
// out      out        out_valid / out_stall   inside_res, in_hole
// cfg      in         cfg_we                  cfg_data (region_count)
//
// a load item writes one table entry when its mask_index is below MASK_COUNT.
// a test item is accepted, checks each mask below region_count (at most MASK_COUNT) and then
// finishes; a box or a degenerate ellipsoid is decided directly, while an ellipsoid runs eleven
// bit-serial shift-add multiplies, each ending once its remaining multiplier bits are zero.
// rst is synchronous and clears region_count and control; the table is not cleared.
// in_stall is high during reset and while a test runs; a finished result waits in the
// output register.
module point_in_volume_mask_regions_core #(
  parameter int MASK_COUNT = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [3:0]                    mask_index,
  input  logic                          mask_shape,
  input  logic                          mask_is_hole,
  input  logic                          relative,
  input  logic signed [COORD_WIDTH-1:0] coord_a,
  input  logic signed [COORD_WIDTH-1:0] coord_b,
  input  logic signed [COORD_WIDTH-1:0] coord_c,
  input  logic signed [COORD_WIDTH-1:0] coord_d,
  input  logic signed [COORD_WIDTH-1:0] coord_e,
  input  logic signed [COORD_WIDTH-1:0] coord_f,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          inside_res,
  output logic                          in_hole,
  input  logic                          cfg_we,
  input  logic [4:0]                    cfg_data
);

  import pivm_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int AW = (MASK_COUNT > 1) ? $clog2(MASK_COUNT) : 1;
  localparam int DW = W + 2;
  localparam int XW = 3 * W + 2;
  localparam int PW = 2 * XW;
  localparam int SW = PW + 2;
  localparam int RW = 6 * W + 2;

  state_t state, state_next;
  mstep_t step;

  logic [4:0] region_count;
  logic [8:0] n;
  logic [8:0] k;
  logic [8:0] idx_wide;

  logic signed [W:0] px, py, pz;
  logic signed [W:0] tx, ty, tz;
  logic any_in, any_hole;
  logic cur_hole;

  logic          ram_we, ram_re;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic signed [W-1:0] x1, y1, z1, x2, y2, z2;
  logic q_shape, q_hole;
  logic box_hit, degenerate, direct_done;
  logic signed [DW-1:0] dx, dy, dz;

  logic [W-1:0]   am, bm, cm;
  logic [DW-1:0]  dxm, dym, dzm;
  logic [2*W-1:0] bc, ac, ab;
  logic [XW-1:0]  u, v, w;
  logic [3*W-1:0] r;
  logic [SW-1:0]  acc;

  logic          mul_start, mul_done;
  logic [XW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic          in_acc, fin_go, ell_hit;

  assign in_acc = in_valid && !in_stall;
  assign fin_go = !out_valid || !out_stall;
  assign n = (9'(region_count) > 9'(MASK_COUNT)) ? 9'(MASK_COUNT) : 9'(region_count);
  assign idx_wide = 9'(mask_index);

  assign tx = relative ? ((W+1)'(coord_a) - (W+1)'(coord_d)) : (W+1)'(coord_a);
  assign ty = relative ? ((W+1)'(coord_b) - (W+1)'(coord_e)) : (W+1)'(coord_b);
  assign tz = relative ? ((W+1)'(coord_c) - (W+1)'(coord_f)) : (W+1)'(coord_c);

  assign ram_we = in_acc && (kind == KIND_LOAD) && (idx_wide < 9'(MASK_COUNT));
  assign ram_wdata = {mask_shape, mask_is_hole, coord_a, coord_b, coord_c,
                      coord_d, coord_e, coord_f};

  pivm_ram #(
    .WIDTH(RW),
    .DEPTH(MASK_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_wide[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (k[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign {q_shape, q_hole, x1, y1, z1, x2, y2, z2} = ram_rdata;

  assign box_hit = (px >= (W+1)'(x1)) && (px <= (W+1)'(x2)) &&
                   (py >= (W+1)'(y1)) && (py <= (W+1)'(y2)) &&
                   (pz >= (W+1)'(z1)) && (pz <= (W+1)'(z2));
  assign degenerate = (x2 == '0) || (y2 == '0) || (z2 == '0);
  assign direct_done = (q_shape == SHAPE_BOX) || degenerate;

  assign dx = DW'(px) - DW'(x1);
  assign dy = DW'(py) - DW'(y1);
  assign dz = DW'(pz) - DW'(z1);

  always_comb begin
    unique case (step)
      MS_BC:   begin mul_a = XW'(bm);  mul_b = XW'(cm); end
      MS_AC:   begin mul_a = XW'(am);  mul_b = XW'(cm); end
      MS_AB:   begin mul_a = XW'(am);  mul_b = XW'(bm); end
      MS_U:    begin mul_a = XW'(dxm); mul_b = XW'(bc); end
      MS_V:    begin mul_a = XW'(dym); mul_b = XW'(ac); end
      MS_W:    begin mul_a = XW'(dzm); mul_b = XW'(ab); end
      MS_R:    begin mul_a = XW'(am);  mul_b = XW'(bc); end
      MS_UU:   begin mul_a = u;        mul_b = u;       end
      MS_VV:   begin mul_a = v;        mul_b = v;       end
      MS_WW:   begin mul_a = w;        mul_b = w;       end
      MS_RR:   begin mul_a = XW'(r);   mul_b = XW'(r);  end
      default: begin mul_a = '0;       mul_b = '0;      end
    endcase
  end

  pivm_mul #(
    .XW(XW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign ell_hit = acc <= SW'(mul_p);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (kind == KIND_TEST)) begin
          state_next = (n == '0) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ:   state_next = ST_EVAL;
      ST_EVAL:   state_next = direct_done ? ST_NEXT : ST_MSTART;
      ST_MSTART: state_next = ST_MWAIT;
      ST_MWAIT: begin
        if (mul_done) begin
          state_next = (step == MS_RR) ? ST_NEXT : ST_MSTART;
        end
      end
      ST_NEXT:   state_next = (k + 9'd1 == n) ? ST_FINISH : ST_READ;
      ST_FINISH: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = rst || (state != ST_IDLE);
    ram_re = (state == ST_READ);
    mul_start = (state == ST_MSTART);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      region_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        region_count <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == ST_FINISH) && fin_go) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && fin_go) begin
      inside_res <= any_in && !any_hole;
      in_hole <= any_hole;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          px <= tx;
          py <= ty;
          pz <= tz;
          k <= '0;
          any_in <= 1'b0;
          any_hole <= 1'b0;
        end
      end
      ST_EVAL: begin
        cur_hole <= q_hole;
        if (direct_done) begin
          if ((q_shape == SHAPE_BOX) && box_hit) begin
            if (q_hole) any_hole <= 1'b1;
            else any_in <= 1'b1;
          end
        end else begin
          step <= MS_BC;
          am <= x2[W-1] ? W'(-x2) : W'(x2);
          bm <= y2[W-1] ? W'(-y2) : W'(y2);
          cm <= z2[W-1] ? W'(-z2) : W'(z2);
          dxm <= dx[DW-1] ? DW'(-dx) : DW'(dx);
          dym <= dy[DW-1] ? DW'(-dy) : DW'(dy);
          dzm <= dz[DW-1] ? DW'(-dz) : DW'(dz);
        end
      end
      ST_MWAIT: begin
        if (mul_done) begin
          if (step != MS_RR) begin
            step <= mstep_t'(step + 4'd1);
          end
          unique case (step)
            MS_BC: bc <= mul_p[2*W-1:0];
            MS_AC: ac <= mul_p[2*W-1:0];
            MS_AB: ab <= mul_p[2*W-1:0];
            MS_U:  u <= mul_p[XW-1:0];
            MS_V:  v <= mul_p[XW-1:0];
            MS_W:  w <= mul_p[XW-1:0];
            MS_R:  r <= mul_p[3*W-1:0];
            MS_UU: acc <= SW'(mul_p);
            MS_VV: acc <= acc + SW'(mul_p);
            MS_WW: acc <= acc + SW'(mul_p);
            MS_RR: begin
              if (ell_hit) begin
                if (cur_hole) any_hole <= 1'b1;
                else any_in <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_NEXT: k <= k + 9'd1;
      default: ;
    endcase
  end

endmodule
